/* hdl/dtq_pkg.sv */
// Package for the deadline timer queue: codes, widths and command/status structs.
// No dependencies.
package dtq_pkg;

  localparam int unsigned TimeW = 63;
  localparam int unsigned IvW   = 40;
  localparam int unsigned TagW  = 32;
  localparam int unsigned LeadW = 16;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
  localparam logic [LeadW-1:0] MinLeadReset = 16'd100;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_CANCELLED = 3'd2,
    KIND_MISSED    = 3'd3,
    KIND_EXPIRED   = 3'd4,
    KIND_DONE      = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_ADD_DONE,
    ST_CANCEL,
    ST_MARK,
    ST_PICK,
    ST_EMIT,
    ST_MIN,
    ST_FINAL,
    ST_OUT
  } state_e;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load;      // capture the input item
    logic scan_clr;  // reset the scan index and search results
    logic scan_add;  // add scan step
    logic add_do;    // write the new timer, form add result
    logic cancel_do; // cancel check and result
    logic mark;      // mark step: flag expired slots
    logic pick;      // pick step: earliest flagged slot
    logic emit;      // emit the picked slot and re-arm or free it
    logic min;       // earliest busy deadline step
    logic final_do;  // form the tick done result
    logic none_do;   // result for the unused action
    logic out_load;  // the result register takes the formed result
  } cmd_t;

  typedef struct packed {
    logic    scan_end;  // index at last slot
    logic    found;     // pick search found a flagged slot
    action_e action;
  } sts_t;

endpackage

/* hdl/dtq_datapath.sv */
// Datapath of the deadline timer queue: slot stores, scan index, search and result.
// Depends on dtq_pkg.
module dtq_datapath #(
  parameter int unsigned Depth = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dtq_pkg::cmd_t             cmd_i,
  output dtq_pkg::sts_t             sts_o,
  input  logic [dtq_pkg::LeadW-1:0] min_lead_i,
  input  logic [1:0]                action_i,
  input  logic [dtq_pkg::TimeW-1:0] now_i,
  input  logic [dtq_pkg::TimeW-1:0] deadline_i,
  input  logic [dtq_pkg::IvW-1:0]   interval_us_i,
  input  logic [3:0]                target_slot_i,
  input  logic [dtq_pkg::TagW-1:0]  target_tag_i,
  output logic [2:0]                kind_o,
  output logic [3:0]                slot_o,
  output logic [dtq_pkg::TagW-1:0]  tag_o,
  output logic                      arm_o,
  output logic [dtq_pkg::TimeW-1:0] arm_delay_us_o,
  output logic                      last_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned SlotW = 4;

  logic [Depth-1:0] busy_q, busy_d, pend_q, pend_d;
  logic [dtq_pkg::TimeW-1:0] dl_q [Depth];
  logic [dtq_pkg::IvW-1:0]   iv_q [Depth];
  logic [dtq_pkg::TagW-1:0]  tg_q [Depth];
  logic [dtq_pkg::TagW-1:0]  cnt_q, cnt_d;

  logic [1:0]                act_q;
  logic [dtq_pkg::TimeW-1:0] now_q, ndl_q;
  logic [dtq_pkg::IvW-1:0]   niv_q;
  logic [3:0]                ts_q;
  logic [dtq_pkg::TagW-1:0]  tt_q;

  logic [IdxW-1:0] idx_q, idx_d;
  // Search state: free slot, earliest flag, best pick.
  logic            free_v_q, free_v_d, early_q, early_d, bv_q, bv_d;
  logic [IdxW-1:0] free_q, free_d, bi_q, bi_d;
  logic [dtq_pkg::TimeW-1:0] bd_q, bd_d;

  // Formed result, then the output register.
  logic [2:0]                rk_q, rk_d;
  logic [3:0]                rs_q, rs_d;
  logic [dtq_pkg::TagW-1:0]  rt_q, rt_d;
  logic                      ra_q, ra_d, rl_q, rl_d;
  logic [dtq_pkg::TimeW-1:0] rw_q, rw_d;

  logic [dtq_pkg::TimeW-1:0] cur_dl, delay_base, diff, rearm;
  logic [dtq_pkg::TimeW:0]   sum;
  logic                      cur_busy, wr_dl;
  logic                      ts_ok;
  logic [IdxW-1:0]           ts_idx;

  assign cur_dl   = dl_q[idx_q];
  assign cur_busy = busy_q[idx_q];
  assign ts_idx   = IdxW'(ts_q);
  assign ts_ok    = ({{(32-SlotW){1'b0}}, ts_q} < 32'(Depth));

  // Arm delay base: the best deadline of the search on the final step, else the new deadline.
  assign delay_base = cmd_i.final_do ? bd_q : ndl_q;
  assign diff = delay_base - now_q;
  assign sum = {1'b0, now_q} + {{(dtq_pkg::TimeW + 1 - dtq_pkg::IvW){1'b0}}, iv_q[bi_q]};
  assign rearm = sum[dtq_pkg::TimeW] ? dtq_pkg::TimeMax : sum[dtq_pkg::TimeW-1:0];

  function automatic logic [dtq_pkg::TimeW-1:0] delay_f(
    input logic [dtq_pkg::TimeW-1:0] w, input logic [dtq_pkg::TimeW-1:0] n,
    input logic [dtq_pkg::TimeW-1:0] d, input logic [dtq_pkg::LeadW-1:0] lead);
    logic [dtq_pkg::TimeW-1:0] l;
    l = {{(dtq_pkg::TimeW - dtq_pkg::LeadW){1'b0}}, lead};
    if (w > n && d > l) return d;
    return l;
  endfunction

  assign sts_o.scan_end = (idx_q == IdxW'(Depth - 1));
  assign sts_o.found    = bv_q;
  assign sts_o.action   = dtq_pkg::action_e'(act_q);

  always_comb begin
    busy_d = busy_q; pend_d = pend_q; cnt_d = cnt_q;
    idx_d = idx_q; free_v_d = free_v_q; free_d = free_q; early_d = early_q;
    bv_d = bv_q; bi_d = bi_q; bd_d = bd_q; wr_dl = 1'b0;
    rk_d = rk_q; rs_d = rs_q; rt_d = rt_q; ra_d = 1'b0; rw_d = '0; rl_d = rl_q;
    // The last mark step also restarts the scan, so the flag is written on its own.
    if (cmd_i.mark) pend_d[idx_q] = cur_busy && (cur_dl <= now_q);
    if (cmd_i.scan_clr) begin
      idx_d = '0; free_v_d = 1'b0; early_d = 1'b1; bv_d = 1'b0;
    end else if (cmd_i.scan_add) begin
      if (cur_busy) begin
        if (!(ndl_q < cur_dl)) early_d = 1'b0;
      end else if (!free_v_q) begin
        free_v_d = 1'b1; free_d = idx_q;
      end
      idx_d = idx_q + 1'b1;
    end else if (cmd_i.mark) begin
      idx_d = idx_q + 1'b1;
    end else if (cmd_i.pick || cmd_i.min) begin
      if ((cmd_i.pick ? pend_q[idx_q] : cur_busy) && (!bv_q || cur_dl < bd_q)) begin
        bv_d = 1'b1; bi_d = idx_q; bd_d = cur_dl;
      end
      idx_d = idx_q + 1'b1;
    end
    rk_d = rk_q; rs_d = rs_q; rt_d = rt_q; rl_d = rl_q;
    if (cmd_i.add_do) begin
      rl_d = 1'b1;
      if (!free_v_q) begin
        rk_d = dtq_pkg::KIND_FULL; rs_d = '0; rt_d = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
        busy_d[free_q] = 1'b1;
        rk_d = dtq_pkg::KIND_ADDED; rs_d = SlotW'(free_q); rt_d = cnt_d;
        ra_d = early_q;
        rw_d = early_q ? delay_f(ndl_q, now_q, diff, min_lead_i) : '0;
      end
    end else if (cmd_i.cancel_do) begin
      rl_d = 1'b1; rs_d = ts_q; rt_d = tt_q;
      if (ts_ok && busy_q[ts_idx] && tg_q[ts_idx] == tt_q) begin
        busy_d[ts_idx] = 1'b0; rk_d = dtq_pkg::KIND_CANCELLED;
      end else begin
        rk_d = dtq_pkg::KIND_MISSED;
      end
    end else if (cmd_i.emit) begin
      rl_d = 1'b0; rk_d = dtq_pkg::KIND_EXPIRED;
      rs_d = SlotW'(bi_q); rt_d = tg_q[bi_q];
      pend_d[bi_q] = 1'b0;
      if (iv_q[bi_q] != '0) wr_dl = 1'b1;
      else busy_d[bi_q] = 1'b0;
    end else if (cmd_i.final_do) begin
      rl_d = 1'b1; rk_d = dtq_pkg::KIND_DONE; rs_d = '0; rt_d = '0;
      ra_d = bv_q;
      rw_d = bv_q ? delay_f(bd_q, now_q, diff, min_lead_i) : '0;
    end else if (cmd_i.none_do) begin
      rl_d = 1'b1; rk_d = dtq_pkg::KIND_DONE; rs_d = '0; rt_d = '0;
    end else begin
      ra_d = ra_q; rw_d = rw_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0; pend_q <= '0; cnt_q <= '0; idx_q <= '0;
      free_v_q <= 1'b0; early_q <= 1'b0; bv_q <= 1'b0;
    end else begin
      busy_q <= busy_d; pend_q <= pend_d; cnt_q <= cnt_d; idx_q <= idx_d;
      free_v_q <= free_v_d; early_q <= early_d; bv_q <= bv_d;
    end
  end

  // The output register takes the result as it is formed, so an expired item
  // is loaded in the same cycle as its emit step.
  always_ff @(posedge clk_i) begin
    free_q <= free_d; bi_q <= bi_d; bd_q <= bd_d;
    rk_q <= rk_d; rs_q <= rs_d; rt_q <= rt_d; ra_q <= ra_d; rw_q <= rw_d; rl_q <= rl_d;
    if (cmd_i.load) begin
      act_q <= action_i; now_q <= now_i; ndl_q <= deadline_i;
      niv_q <= interval_us_i; ts_q <= target_slot_i; tt_q <= target_tag_i;
    end
    if (cmd_i.add_do && free_v_q) begin
      dl_q[free_q] <= ndl_q; iv_q[free_q] <= niv_q; tg_q[free_q] <= cnt_d;
    end
    if (wr_dl) dl_q[bi_q] <= rearm;
    if (cmd_i.out_load) begin
      kind_o <= rk_d; slot_o <= rs_d; tag_o <= rt_d;
      arm_o <= ra_d; arm_delay_us_o <= rw_d; last_o <= rl_d;
    end
  end

  // A slot that is flagged as expired is always busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (pend_q & ~busy_q) == '0)
    else $error("expired flag on a free slot");
  // The tag counter moves only when a timer is added.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.add_do |=> $stable(cnt_q))
    else $error("tag counter moved without an add");
  // An emitted slot is always a found one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.emit |-> bv_q)
    else $error("emit without a pick");

endmodule

/* hdl/dtq_ctrl.sv */
// Controller state machine of the deadline timer queue: sequences scans and handshakes.
// Depends on dtq_pkg.
module dtq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  dtq_pkg::sts_t sts_i,
  output dtq_pkg::cmd_t cmd_o
);

  dtq_pkg::state_e state_q, state_d;
  logic vld_q, vld_d;
  logic slot_free;

  // The output register is free when empty or being taken this cycle.
  assign slot_free = !vld_q || out_ready_i;
  assign in_ready_o = (state_q == dtq_pkg::ST_IDLE);
  assign out_valid_o = vld_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtq_pkg::ST_IDLE: if (in_valid_i) state_d = dtq_pkg::ST_CANCEL;
      dtq_pkg::ST_CANCEL: begin
        // First cycle after load: dispatch on the action.
        unique case (sts_i.action)
          dtq_pkg::ACT_ADD:    state_d = dtq_pkg::ST_ADD_SCAN;
          dtq_pkg::ACT_CANCEL: state_d = dtq_pkg::ST_OUT;
          dtq_pkg::ACT_TICK:   state_d = dtq_pkg::ST_MARK;
          default:             state_d = dtq_pkg::ST_OUT;
        endcase
      end
      dtq_pkg::ST_ADD_SCAN: if (sts_i.scan_end) state_d = dtq_pkg::ST_ADD_DONE;
      dtq_pkg::ST_ADD_DONE: state_d = dtq_pkg::ST_OUT;
      dtq_pkg::ST_MARK: if (sts_i.scan_end) state_d = dtq_pkg::ST_PICK;
      dtq_pkg::ST_PICK: if (sts_i.scan_end) state_d = dtq_pkg::ST_EMIT;
      dtq_pkg::ST_EMIT: begin
        if (!sts_i.found) state_d = dtq_pkg::ST_MIN;
        else if (slot_free) state_d = dtq_pkg::ST_PICK;
      end
      dtq_pkg::ST_MIN: if (sts_i.scan_end) state_d = dtq_pkg::ST_FINAL;
      dtq_pkg::ST_FINAL: state_d = dtq_pkg::ST_OUT;
      dtq_pkg::ST_OUT: if (slot_free) state_d = dtq_pkg::ST_IDLE;
      default: state_d = dtq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    vld_d = vld_q && !out_ready_i;
    unique case (state_q)
      dtq_pkg::ST_IDLE: cmd_o.load = in_valid_i;
      dtq_pkg::ST_CANCEL: begin
        cmd_o.scan_clr = 1'b1;
        unique case (sts_i.action)
          dtq_pkg::ACT_CANCEL: cmd_o.cancel_do = 1'b1;
          dtq_pkg::ACT_NONE:   cmd_o.none_do = 1'b1;
          default: ;
        endcase
      end
      dtq_pkg::ST_ADD_SCAN: cmd_o.scan_add = 1'b1;
      dtq_pkg::ST_ADD_DONE: cmd_o.add_do = 1'b1;
      dtq_pkg::ST_MARK: begin
        cmd_o.mark = 1'b1;
        cmd_o.scan_clr = sts_i.scan_end;
      end
      dtq_pkg::ST_PICK: cmd_o.pick = 1'b1;
      dtq_pkg::ST_EMIT: begin
        if (!sts_i.found) cmd_o.scan_clr = 1'b1;
        else if (slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.out_load = 1'b1;
          vld_d = 1'b1;
          cmd_o.scan_clr = 1'b1;
        end
      end
      dtq_pkg::ST_MIN: cmd_o.min = 1'b1;
      dtq_pkg::ST_FINAL: cmd_o.final_do = 1'b1;
      dtq_pkg::ST_OUT: if (slot_free) begin
        cmd_o.out_load = 1'b1;
        vld_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtq_pkg::ST_IDLE;
      vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q <= vld_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(cmd_o.emit || cmd_o.final_do || cmd_o.add_do))
    else $error("work while ready for a new item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> slot_free)
    else $error("result overwritten before it was taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dtq_pkg::ST_FINAL) |=> (state_q == dtq_pkg::ST_OUT))
    else $error("tick done result skipped");

endmodule

/* hdl/deadline_timer_queue_unit.sv */
// Top level of the deadline timer queue: APB register, controller and datapath.
// Depends on dtq_pkg, dtq_ctrl and dtq_datapath.
//
//   channel  | handshake                  | payload
//   input    | in_valid_i / in_ready_o    | action, now, deadline, interval, target
//   result   | out_valid_o / out_ready_i  | kind, slot, tag, arm, arm_delay_us, last
//   config   | psel/penable/pwrite/pready | paddr, pwdata, prdata (min_lead at 0)
//
// An add scans every slot for a free one and then forms its result; cancel and the unused
// action go straight to the output step. A tick runs marking, one ordered pick pass per
// expired timer and one final empty pass, the earliest deadline scan and the output
// step; all of these passes run on the single shared compare scan.
// Reset clears all busy flags and the tag counter; min_lead returns to 100.
// A stalled result holds the sequencer in its emit or output step.
module deadline_timer_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                action_i,
  input  logic [dtq_pkg::TimeW-1:0] now_i,
  input  logic [dtq_pkg::TimeW-1:0] deadline_i,
  input  logic [dtq_pkg::IvW-1:0]   interval_us_i,
  input  logic [3:0]                target_slot_i,
  input  logic [dtq_pkg::TagW-1:0]  target_tag_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                kind_o,
  output logic [3:0]                slot_o,
  output logic [dtq_pkg::TagW-1:0]  tag_o,
  output logic                      arm_o,
  output logic [dtq_pkg::TimeW-1:0] arm_delay_us_o,
  output logic                      last_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [dtq_pkg::LeadW-1:0] lead_q;
  dtq_pkg::cmd_t cmd;
  dtq_pkg::sts_t sts;

  assign pready = 1'b1;
  assign prdata = paddr ? 32'd0 : {{(32 - dtq_pkg::LeadW){1'b0}}, lead_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= dtq_pkg::MinLeadReset;
    end else if (psel && penable && pwrite && !paddr) begin
      lead_q <= pwdata[dtq_pkg::LeadW-1:0];
    end
  end

  dtq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  dtq_datapath #(.Depth(DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .min_lead_i(lead_q),
    .action_i, .now_i, .deadline_i, .interval_us_i, .target_slot_i, .target_tag_i,
    .kind_o, .slot_o, .tag_o, .arm_o, .arm_delay_us_o, .last_o
  );

endmodule

/* tb/deadline_timer_queue_unit_tb.sv */
// Self-checking testbench for deadline_timer_queue_unit: drives add, cancel, tick and none
// items, predicts every result in a local timer table and checks each accepted
// result in order. Depends on dtq_pkg and the deadline_timer_queue_unit RTL.
module deadline_timer_queue_unit_tb;

  localparam int Depth = 16;
  localparam int DrainCycles = 40;

  typedef struct packed {
    dtq_pkg::kind_e                kind;
    logic [3:0]                    slot;
    logic [dtq_pkg::TagW-1:0]      tag;
    logic                          arm;
    logic [dtq_pkg::TimeW-1:0]     delay;
    logic                          last;
  } timer_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] action_i = '0;
  logic [dtq_pkg::TimeW-1:0] now_i = '0;
  logic [dtq_pkg::TimeW-1:0] deadline_i = '0;
  logic [dtq_pkg::IvW-1:0] interval_us_i = '0;
  logic [3:0] target_slot_i = '0;
  logic [dtq_pkg::TagW-1:0] target_tag_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] kind_o;
  logic [3:0] slot_o;
  logic [dtq_pkg::TagW-1:0] tag_o;
  logic arm_o;
  logic [dtq_pkg::TimeW-1:0] arm_delay_us_o;
  logic last_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  deadline_timer_queue_unit #(.DEPTH(Depth)) dut (.*);

  always #5 clk_i = ~clk_i;

  // Local copy of the timer table.
  logic                      busy_m [Depth];
  logic [dtq_pkg::TimeW-1:0] deadline_m [Depth];
  logic [dtq_pkg::IvW-1:0]   interval_m [Depth];
  logic [dtq_pkg::TagW-1:0]  tag_m [Depth];
  logic [dtq_pkg::TagW-1:0]  tag_count_m;
  logic [dtq_pkg::LeadW-1:0] lead_m;

  timer_result_t pending_results[$];
  int mismatches = 0;
  int burst_left = 0;
  logic [dtq_pkg::TimeW-1:0] clock_now = '0;

  // Receiver stall control; a long hold-off is requested by bumping hold_gen.
  int hold_gen = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int rx_mode = 0;
  int rx_left = 0;

  function automatic logic [dtq_pkg::TimeW-1:0] arm_delay(logic [dtq_pkg::TimeW-1:0] due,
                                                           logic [dtq_pkg::TimeW-1:0] now);
    if (due > now && (due - now) > dtq_pkg::TimeW'(lead_m)) return due - now;
    return dtq_pkg::TimeW'(lead_m);
  endfunction

  function automatic timer_result_t mk(dtq_pkg::kind_e k, logic [3:0] s,
                                       logic [dtq_pkg::TagW-1:0] t, logic a,
                                       logic [dtq_pkg::TimeW-1:0] d, logic l);
    timer_result_t r;
    r.kind = k; r.slot = s; r.tag = t; r.arm = a; r.delay = d; r.last = l;
    return r;
  endfunction

  task automatic predict_timers(dtq_pkg::action_e act, logic [dtq_pkg::TimeW-1:0] now,
                                logic [dtq_pkg::TimeW-1:0] dl, logic [dtq_pkg::IvW-1:0] iv,
                                logic [3:0] ts, logic [dtq_pkg::TagW-1:0] tt);
    int free_slot;
    int pick;
    logic earliest;
    logic any;
    logic [dtq_pkg::TimeW-1:0] best;
    logic due [Depth];
    free_slot = -1;
    earliest = 1'b1;
    any = 1'b0;
    best = '0;
    case (act)
      dtq_pkg::ACT_ADD: begin
        for (int i = 0; i < Depth; i++) begin
          if (busy_m[i]) begin
            if (!(dl < deadline_m[i])) earliest = 1'b0;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (free_slot < 0) begin
          pending_results.push_back(mk(dtq_pkg::KIND_FULL, '0, '0, 1'b0, '0, 1'b1));
        end else begin
          tag_count_m = tag_count_m + 1;
          busy_m[free_slot] = 1'b1;
          deadline_m[free_slot] = dl;
          interval_m[free_slot] = iv;
          tag_m[free_slot] = tag_count_m;
          pending_results.push_back(mk(dtq_pkg::KIND_ADDED, 4'(free_slot), tag_count_m,
                                       earliest, earliest ? arm_delay(dl, now) : '0, 1'b1));
        end
      end
      dtq_pkg::ACT_CANCEL: begin
        if (busy_m[ts] && tag_m[ts] == tt) begin
          busy_m[ts] = 1'b0;
          pending_results.push_back(mk(dtq_pkg::KIND_CANCELLED, ts, tt, 1'b0, '0, 1'b1));
        end else begin
          pending_results.push_back(mk(dtq_pkg::KIND_MISSED, ts, tt, 1'b0, '0, 1'b1));
        end
      end
      dtq_pkg::ACT_TICK: begin
        for (int i = 0; i < Depth; i++) due[i] = busy_m[i] && deadline_m[i] <= now;
        forever begin
          pick = -1;
          for (int i = 0; i < Depth; i++)
            if (due[i] && (pick < 0 || deadline_m[i] < deadline_m[pick])) pick = i;
          if (pick < 0) break;
          due[pick] = 1'b0;
          pending_results.push_back(mk(dtq_pkg::KIND_EXPIRED, 4'(pick), tag_m[pick], 1'b0,
                                       '0, 1'b0));
          if (interval_m[pick] != '0) begin
            if (dtq_pkg::TimeW'(interval_m[pick]) > dtq_pkg::TimeMax - now)
              deadline_m[pick] = dtq_pkg::TimeMax;
            else deadline_m[pick] = now + dtq_pkg::TimeW'(interval_m[pick]);
          end else begin
            busy_m[pick] = 1'b0;
          end
        end
        for (int i = 0; i < Depth; i++)
          if (busy_m[i] && (!any || deadline_m[i] < best)) begin
            best = deadline_m[i];
            any = 1'b1;
          end
        pending_results.push_back(mk(dtq_pkg::KIND_DONE, '0, '0, any,
                                     any ? arm_delay(best, now) : '0, 1'b1));
      end
      default: pending_results.push_back(mk(dtq_pkg::KIND_DONE, '0, '0, 1'b0, '0, 1'b1));
    endcase
  endtask

  task automatic send_item(dtq_pkg::action_e act, logic [dtq_pkg::TimeW-1:0] now,
                           logic [dtq_pkg::TimeW-1:0] dl, logic [dtq_pkg::IvW-1:0] iv,
                           logic [3:0] ts, logic [dtq_pkg::TagW-1:0] tt);
    action_i <= act;
    now_i <= now;
    deadline_i <= dl;
    interval_us_i <= iv;
    target_slot_i <= ts;
    target_tag_i <= tt;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_timers(act, now, dl, iv, ts, tt);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      // Some bursts are long, so stretches without gaps occur too.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 5);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_min_lead(logic [dtq_pkg::LeadW-1:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= 1'b0; pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    lead_m = value;
    @(posedge clk_i);
  endtask

  task automatic check_min_lead();
    psel <= 1'b1; pwrite <= 1'b0; penable <= 1'b0; paddr <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[dtq_pkg::LeadW-1:0] !== lead_m) begin
      mismatches++;
      if (mismatches <= 10)
        $display("min_lead read: expected %0d, got %0d", lead_m,
                 prdata[dtq_pkg::LeadW-1:0]);
    end
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [dtq_pkg::TimeW-1:0] rand_time();
    return dtq_pkg::TimeW'({$urandom(), $urandom()});
  endfunction

  function automatic logic [dtq_pkg::IvW-1:0] rand_interval();
    return dtq_pkg::IvW'({$urandom(), $urandom()});
  endfunction

  // One random item; most are well-formed adds, hits and ticks around a moving clock.
  task automatic send_random_item();
    int sel;
    int s;
    logic [dtq_pkg::TimeW-1:0] dl;
    logic [dtq_pkg::IvW-1:0] iv;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 29) == 0) clock_now = rand_time();
    else clock_now = clock_now + $urandom_range(0, 300);
    if (sel < 40) begin
      dl = ($urandom_range(0, 9) == 0) ? rand_time() : clock_now + $urandom_range(0, 900);
      case ($urandom_range(0, 5))
        0, 1:    iv = '0;
        2:       iv = rand_interval();
        default: iv = dtq_pkg::IvW'($urandom_range(1, 700));
      endcase
      send_item(dtq_pkg::ACT_ADD, clock_now, dl, iv, 4'($urandom()), $urandom());
    end else if (sel < 60) begin
      s = $urandom_range(0, Depth - 1);
      if ($urandom_range(0, 3) != 0) begin
        for (int i = 0; i < Depth; i++)
          if (busy_m[(s + i) % Depth]) begin
            s = (s + i) % Depth;
            break;
          end
        send_item(dtq_pkg::ACT_CANCEL, clock_now, rand_time(), rand_interval(), 4'(s),
                  busy_m[s] ? tag_m[s] : $urandom());
      end else begin
        send_item(dtq_pkg::ACT_CANCEL, clock_now, rand_time(), rand_interval(), 4'(s),
                  ($urandom_range(0, 1) == 0) ? $urandom() : tag_m[s] + 1);
      end
    end else if (sel < 97) begin
      send_item(dtq_pkg::ACT_TICK, clock_now, rand_time(), rand_interval(), 4'($urandom()),
                $urandom());
    end else begin
      send_item(dtq_pkg::ACT_NONE, clock_now, rand_time(), rand_interval(), 4'($urandom()),
                $urandom());
    end
  endtask

  task automatic test_basic_actions();
    check_min_lead();
    send_item(dtq_pkg::ACT_TICK, 63'd0, '0, '0, '0, '0);                  // empty queue
    send_item(dtq_pkg::ACT_ADD, 63'd1000, 63'd1050, '0, '0, '0);          // lead floors delay
    send_item(dtq_pkg::ACT_ADD, 63'd1000, 63'd5000, 40'd10, '0, '0);      // not earliest
    send_item(dtq_pkg::ACT_ADD, 63'd1000, 63'd0, '0, '0, '0);             // already past
    send_item(dtq_pkg::ACT_CANCEL, 63'd1000, '0, '0, 4'd1, 32'd99);       // tag mismatch
    send_item(dtq_pkg::ACT_CANCEL, 63'd1000, '0, '0, 4'd9, 32'd2);        // free slot
    send_item(dtq_pkg::ACT_CANCEL, 63'd1000, '0, '0, 4'd1, 32'd2);        // hit
    send_item(dtq_pkg::ACT_NONE, dtq_pkg::TimeMax, dtq_pkg::TimeMax, {dtq_pkg::IvW{1'b1}},
              4'hf, '1);
    send_item(dtq_pkg::ACT_ADD, 63'd2000, 63'd3000, '0, '0, '0);
    send_item(dtq_pkg::ACT_ADD, 63'd2000, 63'd3000, '0, '0, '0);          // equal deadline tie
    send_item(dtq_pkg::ACT_TICK, 63'd6000, '0, '0, '0, '0);
    send_item(dtq_pkg::ACT_TICK, 63'd6000, '0, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_fill_and_saturate();
    write_min_lead(16'd0);
    check_min_lead();
    for (int i = 0; i < Depth + 1; i++)
      send_item(dtq_pkg::ACT_ADD, dtq_pkg::TimeMax - 63'd5, dtq_pkg::TimeMax - 63'(i),
                {dtq_pkg::IvW{1'b1}}, '0, '0);
    send_item(dtq_pkg::ACT_TICK, dtq_pkg::TimeMax, '0, '0, '0, '0);  // all expire, saturate
    send_item(dtq_pkg::ACT_TICK, dtq_pkg::TimeMax, '0, '0, '0, '0);
    for (int i = 0; i < Depth; i++)
      send_item(dtq_pkg::ACT_CANCEL, '0, '0, '0, 4'(i), tag_m[i]);
    wait_drained();
    write_min_lead(16'hffff);
    check_min_lead();
    send_item(dtq_pkg::ACT_ADD, 63'd0, dtq_pkg::TimeMax, '0, '0, '0);
    send_item(dtq_pkg::ACT_TICK, 63'd10, '0, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_random_phases(int count);
    for (int i = 0; i < count; i++) send_random_item();
    wait_drained();
  endtask

  // The receiver holds off while the sender keeps offering items.
  task automatic test_output_hold_off();
    hold_gen <= hold_gen + 1;
    for (int i = 0; i < 15; i++) send_random_item();
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < Depth; i++) begin
      busy_m[i] = 1'b0; deadline_m[i] = '0; interval_m[i] = '0; tag_m[i] = '0;
    end
    tag_count_m = '0;
    lead_m = dtq_pkg::MinLeadReset;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_actions();
    test_fill_and_saturate();
    write_min_lead(16'd100);
    test_random_phases(60);
    test_output_hold_off();
    write_min_lead(16'($urandom()));
    check_min_lead();
    test_random_phases(70);
    write_min_lead(16'd0);
    test_random_phases(30);
    write_min_lead(16'hffff);
    test_random_phases(30);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    if (hold_gen != hold_seen) begin
      hold_seen <= hold_gen;
      hold_cnt <= 400;
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_left <= $urandom_range(5, 40);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= $urandom_range(0, 1);
        default: out_ready_i <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    timer_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: kind %0d", kind_o);
      end else begin
        exp_r = pending_results.pop_front();
        if (kind_o !== exp_r.kind || slot_o !== exp_r.slot || tag_o !== exp_r.tag ||
            arm_o !== exp_r.arm || arm_delay_us_o !== exp_r.delay || last_o !== exp_r.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected kind %0d slot %0d tag %0d arm %0b ",
                      "delay %0d last %0b, got kind %0d slot %0d tag %0d arm %0b ",
                      "delay %0d last %0b"},
                     exp_r.kind, exp_r.slot, exp_r.tag, exp_r.arm, exp_r.delay, exp_r.last,
                     kind_o, slot_o, tag_o, arm_o, arm_delay_us_o, last_o);
        end
      end
    end
  end

endmodule
